/* hw/rtl/cpf_pkg.sv */
// cpf_pkg: shared types, constants and the byte-wide crc update for the packet framer
// no dependencies; imported by cpf_item_reg, cpf_emitter and crc_packet_framer
package cpf_pkg;

  localparam logic       OP_HEADER  = 1'b0;
  localparam logic       OP_PAYLOAD = 1'b1;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // byte positions of a header request
  localparam logic [2:0] HDR_PRE0   = 3'd0;
  localparam logic [2:0] HDR_PRE1   = 3'd1;
  localparam logic [2:0] HDR_PRE2   = 3'd2;
  localparam logic [2:0] HDR_ID     = 3'd3;
  localparam logic [2:0] HDR_LEN_LO = 3'd4;
  localparam logic [2:0] HDR_LEN_HI = 3'd5;
  localparam logic [2:0] HDR_CRC_LO = 3'd6;
  localparam logic [2:0] HDR_CRC_HI = 3'd7;

  // byte positions of a payload request
  localparam logic [2:0] PAY_DATA   = 3'd0;
  localparam logic [2:0] PAY_CRC_LO = 3'd1;
  localparam logic [2:0] PAY_CRC_HI = 3'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  frame_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } item_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {crc[7:0] ^ b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (t[15]) begin
        t = {t[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        t = {t[14:0], 1'b0};
      end
    end
    return t ^ {8'h00, crc[15:8]};
  endfunction

endpackage

/* hw/rtl/cpf_item_reg.sv */
// cpf_item_reg: one-entry input register holding the request being framed
// depends on cpf_pkg for item_t
module cpf_item_reg
  import cpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  pop
);

  // refill in the same cycle the held request is released
  assign in_ready = !item_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (pop) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* hw/rtl/cpf_emitter.sv */
// cpf_emitter: byte sequencer, frame state, crc register and output register
// depends on cpf_pkg for item_t, byte positions and crc_update
module cpf_emitter
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  item_t      item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [15:0] running_crc;
  logic [15:0] bytes_remaining;
  logic        frame_open;
  logic [2:0]  step;

  logic        is_header;
  logic        skip;
  logic        is_data;
  logic        is_close;
  logic        last_step;
  logic        go;
  logic [7:0]  step_byte;
  logic [15:0] crc_base;
  logic [15:0] crc_data_next;

  assign is_header = (item.op == OP_HEADER);

  // payload with no open frame or nothing left is dropped without output
  assign skip = !is_header && (step == PAY_DATA) && (!frame_open || bytes_remaining == 16'd0);

  always_comb begin
    step_byte = 8'h00;
    if (is_header) begin
      case (step)
        HDR_PRE0, HDR_PRE1, HDR_PRE2: step_byte = PREAMBLE_BYTE;
        HDR_ID:                       step_byte = item.frame_id;
        HDR_LEN_LO:                   step_byte = item.payload_length[7:0];
        HDR_LEN_HI:                   step_byte = item.payload_length[15:8];
        HDR_CRC_LO:                   step_byte = running_crc[7:0];
        HDR_CRC_HI:                   step_byte = running_crc[15:8];
        default:                      step_byte = 8'h00;
      endcase
    end else begin
      case (step)
        PAY_DATA:   step_byte = item.data_byte;
        PAY_CRC_LO: step_byte = running_crc[7:0];
        PAY_CRC_HI: step_byte = running_crc[15:8];
        default:    step_byte = 8'h00;
      endcase
    end
  end

  assign is_data   = is_header ? (step <= HDR_LEN_HI) : (step == PAY_DATA);
  assign is_close  = is_header ? (step == HDR_CRC_HI) : (step == PAY_CRC_HI);
  assign last_step = is_close ||
                     (is_header  && step == HDR_LEN_HI && item.payload_length != 16'd0) ||
                     (!is_header && step == PAY_DATA && bytes_remaining != 16'd1);

  // a header restarts the crc, abandoning any open frame
  assign crc_base      = (is_header && step == HDR_PRE0) ? CRC_INIT : running_crc;
  assign crc_data_next = crc_update(crc_base, step_byte);

  assign go  = item_valid && !skip && (!out_valid || out_ready);
  assign pop = item_valid && (skip || (go && last_step));

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= CRC_INIT;
      bytes_remaining <= 16'd0;
      frame_open      <= 1'b0;
      step            <= 3'd0;
    end else begin
      if (pop) begin
        step <= 3'd0;
      end else if (go) begin
        step <= step + 3'd1;
      end
      if (go) begin
        if (is_data) begin
          running_crc <= crc_data_next;
        end
        if (is_header && step == HDR_LEN_HI) begin
          frame_open      <= 1'b1;
          bytes_remaining <= item.payload_length;
        end
        if (!is_header && step == PAY_DATA) begin
          bytes_remaining <= bytes_remaining - 16'd1;
        end
        if (is_close) begin
          running_crc     <= CRC_INIT;
          bytes_remaining <= 16'd0;
          frame_open      <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte <= step_byte;
      out_last <= is_close;
    end
  end

endmodule

/* hw/rtl/crc_packet_framer.sv */
// crc_packet_framer: top level of the crc16 command frame builder
// depends on cpf_pkg, cpf_item_reg and cpf_emitter
//
// channel  dir  payload                                         handshake
// s        in   tuser op, tdata id / length / data byte         s_tvalid, s_tready
// m        out  tdata frame byte, tlast end of frame            m_tvalid, m_tready
//
// one output byte leaves per cycle from the output register unless m stalls; the byte sequencer sets the rate
// payload request: its data byte, then the crc low and high bytes when it is the last byte of the frame
// header request: preamble, id and length bytes, then the crc when the length is zero; ignored payload: no output
// next request is taken in the cycle the held one finishes, so payload streams back to back
// reset: no frame open, crc 0xffff, no byte pending; a stall on m simply holds the sequencer
module crc_packet_framer
  import cpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // frame_id [7:0], payload_length [23:8], data_byte [31:24]
  input  logic        s_tuser,  // op: 0 header, 1 payload byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // frame_byte [7:0]
  output logic        m_tlast   // end_of_frame, on the crc high byte
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  pop;

  // unpack the request
  assign in_item.op             = s_tuser;
  assign in_item.frame_id       = s_tdata[7:0];
  assign in_item.payload_length = s_tdata[23:8];
  assign in_item.data_byte      = s_tdata[31:24];

  // holding register between the slave side and the sequencer
  cpf_item_reg u_item_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop)
  );

  // byte sequencer with crc and frame state, ending in the output register
  cpf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule
